@@ design/assert_macros.svh @@
// assertion helpers shared by the breaker rtl
// included by the modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FBEH_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
`define FBEH_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("forbidden condition seen");
`else
`define FBEH_ASSERT(label, clk, rst_n, prop)
`define FBEH_NEVER(label, clk, rst_n, expr)
`endif
`endif

@@ design/fbeh_pkg.sv @@
// shared types, widths and codes of the failure breaker
// no dependencies
`default_nettype none
package fbeh_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned TimerW  = 20;
  localparam int unsigned WeightW = 8;
  localparam int unsigned LevelW  = 2;
  localparam int unsigned OpW     = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned NumLevelsDefault = 3;

  typedef enum logic [OpW-1:0] {
    OpTick    = 3'd0,
    OpFailure = 3'd1,
    OpSuccess = 3'd2,
    OpQuery   = 3'd3,
    OpRestart = 3'd4
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegMaxFailures = 3'd0,
    RegWindow      = 3'd1,
    RegHold0       = 3'd2,
    RegHold1       = 3'd3,
    RegHold2       = 3'd4
  } cfg_reg_e;

  localparam logic [1:0] VerdictNone   = 2'd0;
  localparam logic [1:0] VerdictAccept = 2'd1;
  localparam logic [1:0] VerdictDrop   = 2'd2;

  localparam logic [CountW-1:0] MaxFailuresRst = 16'd5;
  localparam logic [TimerW-1:0] WindowRst      = 20'd20;
  localparam logic [TimerW-1:0] Hold0Rst       = 20'd60;
  localparam logic [TimerW-1:0] Hold1Rst       = 20'd300;
  localparam logic [TimerW-1:0] Hold2Rst       = 20'd600;

  typedef struct packed {
    logic [CountW-1:0] max_failures;
    logic [TimerW-1:0] window_ticks;
    logic [TimerW-1:0] hold_level0;
    logic [TimerW-1:0] hold_level1;
    logic [TimerW-1:0] hold_level2;
  } cfg_t;

  typedef struct packed {
    logic              already_decided;
    logic              fail_open;
    logic [WeightW-1:0] weight;
    logic [OpW-1:0]    operation;
  } item_t;

  typedef struct packed {
    logic [CountW-1:0] failure_total;
    logic [LevelW-1:0] escalation_level;
    logic [1:0]        verdict;
    logic              in_hold;
  } result_t;

endpackage
`default_nettype wire

@@ design/fbeh_cfg.sv @@
// configuration register file of the failure breaker
// depends on fbeh_pkg
`default_nettype none
module fbeh_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             we_i,
  input  wire logic [fbeh_pkg::CfgIdxW-1:0]     idx_i,
  input  wire logic [fbeh_pkg::CfgDataW-1:0]    data_i,
  output fbeh_pkg::cfg_t                        cfg_o
);

  fbeh_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        fbeh_pkg::RegMaxFailures: cfg_d.max_failures = data_i[fbeh_pkg::CountW-1:0];
        fbeh_pkg::RegWindow:      cfg_d.window_ticks = data_i[fbeh_pkg::TimerW-1:0];
        fbeh_pkg::RegHold0:       cfg_d.hold_level0  = data_i[fbeh_pkg::TimerW-1:0];
        fbeh_pkg::RegHold1:       cfg_d.hold_level1  = data_i[fbeh_pkg::TimerW-1:0];
        fbeh_pkg::RegHold2:       cfg_d.hold_level2  = data_i[fbeh_pkg::TimerW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_failures <= fbeh_pkg::MaxFailuresRst;
      cfg_q.window_ticks <= fbeh_pkg::WindowRst;
      cfg_q.hold_level0  <= fbeh_pkg::Hold0Rst;
      cfg_q.hold_level1  <= fbeh_pkg::Hold1Rst;
      cfg_q.hold_level2  <= fbeh_pkg::Hold2Rst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ design/fbeh_core.sv @@
// breaker state and per-event update, one event per cycle
// depends on fbeh_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module fbeh_core #(
  parameter int unsigned NUM_LEVELS = fbeh_pkg::NumLevelsDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire fbeh_pkg::cfg_t cfg_i,
  input  wire logic           item_valid_i,
  input  wire fbeh_pkg::item_t item_i,
  output fbeh_pkg::result_t   result_o
);

  localparam logic [fbeh_pkg::LevelW-1:0] TopLevel = fbeh_pkg::LevelW'(NUM_LEVELS - 1);

  logic [fbeh_pkg::CountW-1:0] count_q, count_d;
  logic [fbeh_pkg::LevelW-1:0] level_q, level_d;
  logic                        hold_q, hold_d;
  logic [fbeh_pkg::TimerW-1:0] hold_rem_q, hold_rem_d;
  logic [fbeh_pkg::TimerW-1:0] win_rem_q, win_rem_d;

  logic [fbeh_pkg::CountW:0]   sum;
  logic [fbeh_pkg::CountW-1:0] sat_sum;
  logic [fbeh_pkg::TimerW-1:0] hold_len;
  logic                        q_hold;
  logic [1:0]                  verdict;

  assign sum     = {1'b0, count_q} + {{(fbeh_pkg::CountW+1-fbeh_pkg::WeightW){1'b0}},
                                      item_i.weight};
  assign sat_sum = sum[fbeh_pkg::CountW] ? '1 : sum[fbeh_pkg::CountW-1:0];

  always_comb begin
    case (level_q)
      2'd0:    hold_len = cfg_i.hold_level0;
      2'd1:    hold_len = cfg_i.hold_level1;
      default: hold_len = cfg_i.hold_level2;
    endcase
  end

  always_comb begin
    count_d    = count_q;
    level_d    = level_q;
    hold_d     = hold_q;
    hold_rem_d = hold_rem_q;
    win_rem_d  = win_rem_q;
    q_hold     = 1'b0;
    verdict    = fbeh_pkg::VerdictNone;
    case (item_i.operation)
      fbeh_pkg::OpTick: begin
        if (win_rem_q != '0) win_rem_d = win_rem_q - 1'b1;
        if (hold_rem_q != '0) hold_rem_d = hold_rem_q - 1'b1;
      end
      fbeh_pkg::OpFailure: begin
        if (!item_i.already_decided) begin
          verdict = item_i.fail_open ? fbeh_pkg::VerdictAccept : fbeh_pkg::VerdictDrop;
          count_d = sat_sum;
          if (win_rem_q == '0) begin
            win_rem_d = cfg_i.window_ticks;
          end else if (sat_sum > cfg_i.max_failures) begin
            hold_d     = 1'b1;
            hold_rem_d = hold_len;
            level_d    = (level_q < TopLevel) ? level_q + 1'b1 : TopLevel;
          end
        end
      end
      fbeh_pkg::OpSuccess: begin
        if (win_rem_q == '0 && count_q == '0) level_d = '0;
      end
      fbeh_pkg::OpQuery: begin
        if (hold_q && hold_rem_q != '0) begin
          q_hold = 1'b1;
        end else begin
          hold_d    = 1'b0;
          count_d   = '0;
          win_rem_d = cfg_i.window_ticks;
        end
      end
      fbeh_pkg::OpRestart: begin
        level_d    = '0;
        count_d    = '0;
        hold_d     = 1'b0;
        hold_rem_d = '0;
        win_rem_d  = cfg_i.window_ticks;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      level_q    <= '0;
      hold_q     <= 1'b0;
      hold_rem_q <= '0;
      win_rem_q  <= fbeh_pkg::WindowRst;
    end else if (item_valid_i) begin
      count_q    <= count_d;
      level_q    <= level_d;
      hold_q     <= hold_d;
      hold_rem_q <= hold_rem_d;
      win_rem_q  <= win_rem_d;
    end
  end

  assign result_o.in_hold          = q_hold;
  assign result_o.verdict          = verdict;
  assign result_o.escalation_level = level_d;
  assign result_o.failure_total    = count_d;

  `FBEH_NEVER(level_over_top, clk_i, rst_ni, level_q > TopLevel)
  `FBEH_ASSERT(restart_clears, clk_i, rst_ni,
    (item_valid_i && item_i.operation == fbeh_pkg::OpRestart) |=>
    (level_q == '0 && count_q == '0 && !hold_q))
  `FBEH_NEVER(query_hold_when_idle, clk_i, rst_ni, q_hold && (!hold_q || hold_rem_q == '0))

endmodule
`default_nettype wire

@@ design/fbeh_outbuf.sv @@
// two-entry result buffer: output register plus skid stage
// depends on fbeh_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module fbeh_outbuf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire fbeh_pkg::result_t data_i,
  output logic               ready_o,
  output logic               valid_o,
  input  wire logic          pop_ready_i,
  output fbeh_pkg::result_t  data_o
);

  logic              out_valid_q, out_valid_d;
  logic              sk_valid_q, sk_valid_d;
  fbeh_pkg::result_t out_q, out_d;
  fbeh_pkg::result_t sk_q, sk_d;
  logic              pop;

  assign pop     = out_valid_q && pop_ready_i;
  assign ready_o = !sk_valid_q;

  always_comb begin
    out_valid_d = out_valid_q;
    sk_valid_d  = sk_valid_q;
    out_d       = out_q;
    sk_d        = sk_q;
    if (sk_valid_q) begin
      if (pop) begin
        out_d      = sk_q;
        sk_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        sk_d       = data_i;
        sk_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sk_valid_q  <= sk_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sk_q  <= sk_d;
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  `FBEH_NEVER(skid_without_head, clk_i, rst_ni, sk_valid_q && !out_valid_q)
  `FBEH_ASSERT(drain_empties, clk_i, rst_ni,
    (pop && !push_i && !sk_valid_q) |=> !out_valid_q)

endmodule
`default_nettype wire

@@ design/failure_breaker_escalating_hold_top.sv @@
// top level of the failure breaker with escalating bypass hold
// depends on fbeh_pkg, fbeh_cfg, fbeh_core and fbeh_outbuf
`default_nettype none
// Event-driven failure breaker. Each input transfer is one event (tick, failure,
// success, hold query, restart) and yields exactly one result transfer. Events
// are processed at one per clock while tready is high: the state update is a
// single saturating add, a few compares and timer reloads between the state
// registers, and a result enters a two-entry output buffer, so input stays
// ready while one result waits. Input tready drops only when both buffer
// entries are full. Results are driven from the buffer's output register. Hold
// and window lengths take effect at the next timer reload and the failure limit
// at the next failure; indexes above 4 are ignored. No clearing pass after reset.
module failure_breaker_escalating_hold_top #(
  parameter int unsigned NUM_LEVELS = fbeh_pkg::NumLevelsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] weight, [8] fail_open, [9] already_decided, [15:10] zero
  input  wire logic [15:0] s_axis_tdata,
  // [2:0] operation
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] in_hold, [2:1] verdict, [4:3] escalation_level, [20:5] failure_total,
  // [23:21] zero
  output logic [23:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [fbeh_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [fbeh_pkg::CfgDataW-1:0] cfg_data_i
);

  fbeh_pkg::cfg_t    cfg;
  fbeh_pkg::item_t   item;
  fbeh_pkg::result_t result;
  fbeh_pkg::result_t result_buf;
  logic              in_xfer;

  assign item.operation       = s_axis_tuser;
  assign item.weight          = s_axis_tdata[7:0];
  assign item.fail_open       = s_axis_tdata[8];
  assign item.already_decided = s_axis_tdata[9];
  assign in_xfer              = s_axis_tvalid && s_axis_tready;

  fbeh_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  fbeh_core #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (in_xfer),
    .item_i       (item),
    .result_o     (result)
  );

  fbeh_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_xfer),
    .data_i      (result),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (result_buf)
  );

  assign m_axis_tdata = {3'b000, result_buf};

endmodule
`default_nettype wire
